### rtl/gfs_pkg.sv
// Shared types, constants and helper functions for the Gaussian force spread unit.
// Depends on nothing; every RTL file of the block imports it.
`default_nettype none

package gfs_pkg;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_NODE  = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		CFG_DIMS    = 3'd0,
		CFG_HUB_X   = 3'd1,
		CFG_HUB_Y   = 3'd2,
		CFG_HUB_Z   = 3'd3,
		CFG_SHAFT_X = 3'd4,
		CFG_SHAFT_Y = 3'd5,
		CFG_SHAFT_Z = 3'd6
	} cfg_index_t;

	typedef enum logic [2:0] {
		DV_INV_A  = 3'd0,
		DV_INV_B  = 3'd1,
		DV_NORM_A = 3'd2,
		DV_NORM_B = 3'd3,
		DV_NORM_C = 3'd4
	} div_step_t;

	typedef enum logic [1:0] {
		SH_0  = 2'd0,
		SH_16 = 2'd1,
		SH_30 = 2'd2
	} shift_t;

	typedef enum logic [1:0] {
		CAP_NONE = 2'd0,
		CAP_X    = 2'd1,
		CAP_LIM  = 2'd2
	} cap_t;

	typedef enum logic [3:0] {
		D_D2   = 4'd0,
		D_X    = 4'd1,
		D_G    = 4'd2,
		D_NF   = 4'd3,
		D_THR  = 4'd4,
		D_RDOT = 4'd5,
		D_RP   = 4'd6,
		D_CSET = 4'd7,
		D_CSUB = 4'd8,
		D_TRQ  = 4'd9
	} dest_t;

	// One step of the shared multiplier: operands, scaling, cap and destination.
	typedef struct packed {
		logic [63:0] a_raw;
		logic        a_signed;
		logic [31:0] b_raw;
		logic        b_signed;
		shift_t      sh;
		cap_t        cap;
		dest_t       dest;
		logic [1:0]  lane;
	} mul_op_t;

	localparam logic [62:0] LIM        = 63'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [62:0] X_END      = 63'd1 << 20;
	localparam logic [63:0] DIV_ONE_48 = 64'd1 << 48;
	localparam logic [63:0] C3_NORM    = 64'd3312797681000000000;
	localparam logic [63:0] C2_NORM    = 64'd89596267790000;
	localparam logic [63:0] CAP32      = 64'h0000_0000_FFFF_FFFF;

	localparam logic signed [64:0] I32_MAX = 65'sd2147483647;
	localparam logic signed [64:0] I32_MIN = -65'sd2147483648;
	localparam logic signed [64:0] T48_MAX = 65'sd140737488355327;
	localparam logic signed [64:0] T48_MIN = -65'sd140737488355328;

	function automatic logic [63:0] div_small(input logic [63:0] v, input logic [3:0] k);
		logic [63:0] q;
		case (k)
			4'd2:    q = v / 64'd2;
			4'd3:    q = v / 64'd3;
			4'd4:    q = v / 64'd4;
			4'd5:    q = v / 64'd5;
			4'd6:    q = v / 64'd6;
			4'd7:    q = v / 64'd7;
			4'd8:    q = v / 64'd8;
			4'd9:    q = v / 64'd9;
			4'd10:   q = v / 64'd10;
			4'd11:   q = v / 64'd11;
			4'd12:   q = v / 64'd12;
			default: q = v;
		endcase
		return q;
	endfunction

	// exp(-64 t / 2^30) in Q16.16: series at t in Q30, then six squarings.
	function automatic logic [31:0] exp_entry(input logic [63:0] t);
		logic [63:0]        term;
		logic [63:0]        r;
		logic signed [63:0] sum;
		term = 64'd1 << 30;
		sum  = $signed(term);
		for (int k = 1; k <= 12; k++) begin
			term = div_small((term * t) >> 30, 4'(k));
			if (k % 2 == 1)
				sum = sum - $signed(term);
			else
				sum = sum + $signed(term);
		end
		r = sum[63] ? 64'd0 : $unsigned(sum);
		for (int k = 0; k < 6; k++)
			r = (r * r + (64'd1 << 29)) >> 30;
		return 32'((r + (64'd1 << 13)) >> 14);
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [64:0] v);
		logic signed [31:0] c;
		if (v > I32_MAX)
			c = 32'sh7FFF_FFFF;
		else if (v < I32_MIN)
			c = 32'sh8000_0000;
		else
			c = v[31:0];
		return c;
	endfunction

	function automatic logic signed [47:0] clamp48(input logic signed [64:0] v);
		logic signed [47:0] c;
		if (v > T48_MAX)
			c = 48'sh7FFF_FFFF_FFFF;
		else if (v < T48_MIN)
			c = 48'sh8000_0000_0000;
		else
			c = v[47:0];
		return c;
	endfunction

	function automatic logic [31:0] cap32(input logic [63:0] v);
		return (v > CAP32) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

endpackage

`default_nettype wire

### rtl/gaussian_force_spread_thrust_torque_unit.sv
// Top level of the Gaussian force spread unit: sequencer, shared multiplier, divider.
// Depends on gfs_pkg for types, constants and the exp table function.
`default_nettype none

// The block takes one request at a time. A load request stores an actuator
// point and then runs a one-bit-per-cycle restoring divider four times in 2D
// or five times in 3D. A node request runs 26 fixed-point products through
// a single 32 by 32 multiplier, each through a low half, a high half and a
// scale and accumulate state, plus one exp table read. A clear request, or
// an unused request type, goes straight to the result hand-over. The result
// of every request sits in an output register until it is taken, and the
// next request is accepted while it waits. The exp table is a constant built
// at elaboration with EXP_TABLE_ENTRIES entries over (d/eps)^2 in [0, 16).
// Configuration registers must only be written while the block is idle.
module gaussian_force_spread_thrust_torque_unit #(
	parameter int EXP_TABLE_ENTRIES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] force_x,
	input  logic signed [31:0] force_y,
	input  logic signed [31:0] force_z,
	input  logic [30:0]        spread_width,
	input  logic [30:0]        node_volume,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [31:0] node_force_x,
	output logic signed [31:0] node_force_y,
	output logic signed [31:0] node_force_z,
	output logic signed [47:0] thrust_x,
	output logic signed [47:0] thrust_y,
	output logic signed [47:0] thrust_z,
	output logic signed [47:0] torque_x,
	output logic signed [47:0] torque_y,
	output logic signed [47:0] torque_z
);
	import gfs_pkg::*;

	localparam int          IDX_W     = $clog2(EXP_TABLE_ENTRIES);
	localparam logic [63:0] ENTRIES64 = 64'(EXP_TABLE_ENTRIES);
	localparam logic [39:0] ENTRIES40 = 40'(EXP_TABLE_ENTRIES);
	localparam logic [39:0] HALF40    = 40'd1 << 19;
	localparam logic [5:0]  DIV_LAST  = 6'd63;

	// Step numbers of the node sequence.
	localparam logic [4:0] OP_H0    = 5'd0;
	localparam logic [4:0] OP_X     = 5'd3;
	localparam logic [4:0] OP_G     = 5'd4;
	localparam logic [4:0] OP_NF0   = 5'd5;
	localparam logic [4:0] OP_THR0  = 5'd8;
	localparam logic [4:0] OP_RDOT0 = 5'd11;
	localparam logic [4:0] OP_RP0   = 5'd14;
	localparam logic [4:0] OP_TQ0   = 5'd17;
	localparam logic [4:0] OP_LAST  = 5'd25;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DIV  = 7'b0000010,
		S_MLO  = 7'b0000100,
		S_MHI  = 7'b0001000,
		S_MFIN = 7'b0010000,
		S_LOOK = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q;

	// Configuration.
	logic [1:0]         dims_q;
	logic signed [31:0] hub_q   [3];
	logic signed [17:0] shaft_q [3];

	// Actuator point and its precomputed width terms.
	logic signed [31:0] pp_q [3];
	logic signed [31:0] pf_q [3];
	logic [30:0]        width_q;
	logic [31:0]        inv_q;
	logic [31:0]        norm_q;

	// Running totals.
	logic signed [47:0] thrust_q [3];
	logic signed [47:0] torque_q [3];

	// Node request working registers.
	logic signed [31:0] np_q [3];
	logic [30:0]        vol_q;
	logic signed [31:0] nf_q [3];
	logic [63:0]        d2_q;
	logic [20:0]        x_q;
	logic [31:0]        e_q;
	logic [31:0]        g_q;
	logic signed [39:0] rdot_q;
	logic signed [39:0] rp_q [3];
	logic signed [55:0] c_q;
	logic [4:0]         op_q;
	logic [63:0]        p_lo_q;
	logic [63:0]        p_hi_q;

	// Divider.
	logic [63:0] div_num_q;
	logic [30:0] div_rem_q;
	logic [5:0]  div_cnt_q;
	div_step_t   div_step_q;

	// Output register.
	logic               res_valid_q;
	logic signed [31:0] res_nf_q  [3];
	logic signed [47:0] res_thr_q [3];
	logic signed [47:0] res_trq_q [3];

	// The exp table is pure constant logic.
	logic [31:0] exp_rom [EXP_TABLE_ENTRIES];

	for (genvar i = 0; i < EXP_TABLE_ENTRIES; i++) begin : g_rom
		localparam logic [63:0] T_ARG = (64'(i) << 28) / ENTRIES64;
		assign exp_rom[i] = exp_entry(T_ARG);
	end

	// In two dimensions every z term of the node sequence is forced to zero.
	logic               two;
	logic signed [32:0] diff_w [3];
	logic [32:0]        dmag_w [3];
	logic [31:0]        h_w    [3];
	logic signed [32:0] r_w    [3];
	logic signed [17:0] s_w    [3];
	logic signed [31:0] f_w    [3];

	assign two = (dims_q == 2'd2);

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			diff_w[j] = 33'(np_q[j]) - 33'(pp_q[j]);
			dmag_w[j] = diff_w[j][32] ? 33'(-diff_w[j]) : 33'(diff_w[j]);
			if (j == 2 && two) begin
				h_w[j] = '0;
				r_w[j] = '0;
				s_w[j] = '0;
				f_w[j] = '0;
			end else begin
				h_w[j] = dmag_w[j][32:1];
				r_w[j] = 33'(np_q[j]) - 33'(hub_q[j]);
				s_w[j] = shaft_q[j];
				f_w[j] = pf_q[j];
			end
		end
	end

	// Decode of the current node step into multiplier operands and destination.
	mul_op_t op;

	always_comb begin
		op     = '0;
		op.sh  = SH_16;
		op.cap = CAP_LIM;
		unique case (op_q) inside
			[OP_H0:OP_H0 + 5'd2]: begin
				op.lane  = 2'(op_q - OP_H0);
				op.a_raw = 64'(h_w[op.lane]);
				op.b_raw = h_w[op.lane];
				op.sh    = SH_0;
				op.cap   = CAP_NONE;
				op.dest  = D_D2;
			end
			OP_X: begin
				op.a_raw = d2_q;
				op.b_raw = inv_q;
				op.sh    = SH_30;
				op.cap   = CAP_X;
				op.dest  = D_X;
			end
			OP_G: begin
				op.a_raw = 64'(norm_q);
				op.b_raw = e_q;
				op.dest  = D_G;
			end
			[OP_NF0:OP_NF0 + 5'd2]: begin
				op.lane     = 2'(op_q - OP_NF0);
				op.a_raw    = 64'(f_w[op.lane]);
				op.a_signed = 1'b1;
				op.b_raw    = g_q;
				op.dest     = D_NF;
			end
			[OP_THR0:OP_THR0 + 5'd2]: begin
				op.lane     = 2'(op_q - OP_THR0);
				op.a_raw    = 64'(nf_q[op.lane]);
				op.a_signed = 1'b1;
				op.b_raw    = 32'(vol_q);
				op.dest     = D_THR;
			end
			[OP_RDOT0:OP_RDOT0 + 5'd2]: begin
				op.lane     = 2'(op_q - OP_RDOT0);
				op.a_raw    = 64'(r_w[op.lane]);
				op.a_signed = 1'b1;
				op.b_raw    = 32'(s_w[op.lane]);
				op.b_signed = 1'b1;
				op.dest     = D_RDOT;
			end
			[OP_RP0:OP_RP0 + 5'd2]: begin
				op.lane     = 2'(op_q - OP_RP0);
				op.a_raw    = 64'(rdot_q);
				op.a_signed = 1'b1;
				op.b_raw    = 32'(s_w[op.lane]);
				op.b_signed = 1'b1;
				op.dest     = D_RP;
			end
			OP_TQ0: begin
				op.a_raw = 64'(rp_q[1]);
				op.b_raw = nf_q[2];
				op.dest  = D_CSET;
			end
			OP_TQ0 + 5'd1: begin
				op.a_raw = 64'(rp_q[2]);
				op.b_raw = nf_q[1];
				op.dest  = D_CSUB;
			end
			OP_TQ0 + 5'd3: begin
				op.a_raw = 64'(rp_q[2]);
				op.b_raw = nf_q[0];
				op.dest  = D_CSET;
			end
			OP_TQ0 + 5'd4: begin
				op.a_raw = 64'(rp_q[0]);
				op.b_raw = nf_q[2];
				op.dest  = D_CSUB;
			end
			OP_TQ0 + 5'd6: begin
				op.a_raw = 64'(rp_q[0]);
				op.b_raw = nf_q[1];
				op.dest  = D_CSET;
			end
			OP_TQ0 + 5'd7: begin
				op.a_raw = 64'(rp_q[1]);
				op.b_raw = nf_q[0];
				op.dest  = D_CSUB;
			end
			OP_TQ0 + 5'd2, OP_TQ0 + 5'd5, OP_LAST: begin
				op.lane  = (op_q == OP_TQ0 + 5'd2) ? 2'd0 :
				           (op_q == OP_TQ0 + 5'd5) ? 2'd1 : 2'd2;
				op.a_raw = 64'(c_q);
				op.b_raw = 32'(vol_q);
				op.dest  = D_TRQ;
			end
			default: begin
				op.dest = D_D2;
			end
		endcase
		// The cross product terms carry signed operands; the torque step signs only its first operand.
		if (op.dest == D_CSET || op.dest == D_CSUB || op.dest == D_TRQ) begin
			op.a_signed = 1'b1;
			op.b_signed = (op.dest != D_TRQ);
		end
	end

	// Shared multiplier: magnitudes are multiplied, the sign is applied after
	// scaling so that every product truncates toward zero.
	logic        a_neg;
	logic        b_neg;
	logic        neg;
	logic [63:0] a_mag;
	logic [31:0] b_mag;
	logic [31:0] mul_a;
	logic [63:0] product;

	assign a_neg   = op.a_signed & op.a_raw[63];
	assign b_neg   = op.b_signed & op.b_raw[31];
	assign neg     = a_neg ^ b_neg;
	assign a_mag   = a_neg ? (64'd0 - op.a_raw) : op.a_raw;
	assign b_mag   = b_neg ? (32'd0 - op.b_raw) : op.b_raw;
	assign mul_a   = (state_q == S_MHI) ? a_mag[63:32] : a_mag[31:0];
	assign product = {32'd0, mul_a} * {32'd0, b_mag};

	logic [95:0]        full;
	logic [95:0]        shifted;
	logic [62:0]        m;
	logic [63:0]        m64;
	logic signed [63:0] sv;
	logic signed [64:0] thr_sum;
	logic signed [64:0] trq_sum;

	assign full = {p_hi_q, 32'd0} + {32'd0, p_lo_q};

	always_comb begin
		case (op.sh)
			SH_0:    shifted = full;
			SH_30:   shifted = full >> 30;
			default: shifted = full >> 16;
		endcase
		case (op.cap)
			CAP_X:   m = (shifted > 96'(X_END)) ? X_END : shifted[62:0];
			CAP_LIM: m = (shifted > 96'(LIM)) ? LIM : shifted[62:0];
			default: m = shifted[62:0];
		endcase
		m64     = {1'b0, m};
		sv      = neg ? $signed(64'd0 - m64) : $signed(m64);
		thr_sum = 65'(thrust_q[op.lane]) + 65'(sv);
		trq_sum = 65'(torque_q[op.lane]) + 65'(sv);
	end

	// Exp table read: index = round(x * entries / 16), zero past the end.
	logic [39:0] idx_prod;
	logic [39:0] idx_full;
	logic [31:0] e_lookup;

	assign idx_prod = 40'(x_q) * ENTRIES40 + HALF40;
	assign idx_full = idx_prod >> 20;
	assign e_lookup = (!x_q[20] && idx_full < ENTRIES40) ? exp_rom[idx_full[IDX_W-1:0]] : '0;

	// Restoring divider step, one quotient bit per cycle.
	logic [31:0] rem_sh;
	logic        div_ge;
	logic [30:0] rem_nx;
	logic [63:0] q_nx;

	assign rem_sh = {div_rem_q, div_num_q[63]};
	assign div_ge = (rem_sh >= {1'b0, width_q});
	assign rem_nx = div_ge ? 31'(rem_sh - {1'b0, width_q}) : rem_sh[30:0];
	assign q_nx   = {div_num_q[62:0], div_ge};

	assign req_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dims_q      <= 2'd3;
			width_q     <= 31'd65536;
			inv_q       <= 32'd65536;
			norm_q      <= '0;
			vol_q       <= '0;
			d2_q        <= '0;
			x_q         <= '0;
			e_q         <= '0;
			g_q         <= '0;
			rdot_q      <= '0;
			c_q         <= '0;
			op_q        <= '0;
			p_lo_q      <= '0;
			p_hi_q      <= '0;
			div_num_q   <= '0;
			div_rem_q   <= '0;
			div_cnt_q   <= '0;
			div_step_q  <= DV_INV_A;
			res_valid_q <= 1'b0;
			for (int j = 0; j < 3; j++) begin
				hub_q[j]     <= '0;
				shaft_q[j]   <= '0;
				pp_q[j]      <= '0;
				pf_q[j]      <= '0;
				thrust_q[j]  <= '0;
				torque_q[j]  <= '0;
				np_q[j]      <= '0;
				nf_q[j]      <= '0;
				rp_q[j]      <= '0;
				res_nf_q[j]  <= '0;
				res_thr_q[j] <= '0;
				res_trq_q[j] <= '0;
			end
			shaft_q[0] <= 18'sd65536;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DIMS:    dims_q     <= cfg_data[1:0];
					CFG_HUB_X:   hub_q[0]   <= cfg_data;
					CFG_HUB_Y:   hub_q[1]   <= cfg_data;
					CFG_HUB_Z:   hub_q[2]   <= cfg_data;
					CFG_SHAFT_X: shaft_q[0] <= cfg_data[17:0];
					CFG_SHAFT_Y: shaft_q[1] <= cfg_data[17:0];
					CFG_SHAFT_Z: shaft_q[2] <= cfg_data[17:0];
					default: ;
				endcase
			end

			if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						unique case (req_type)
							REQ_LOAD: begin
								pp_q[0]    <= pos_x;
								pp_q[1]    <= pos_y;
								pp_q[2]    <= pos_z;
								pf_q[0]    <= force_x;
								pf_q[1]    <= force_y;
								pf_q[2]    <= force_z;
								width_q    <= (spread_width == '0) ? 31'd1 : spread_width;
								div_num_q  <= DIV_ONE_48;
								div_rem_q  <= '0;
								div_cnt_q  <= '0;
								div_step_q <= DV_INV_A;
								for (int j = 0; j < 3; j++)
									nf_q[j] <= '0;
								state_q <= S_DIV;
							end
							REQ_NODE: begin
								np_q[0] <= pos_x;
								np_q[1] <= pos_y;
								np_q[2] <= pos_z;
								vol_q   <= node_volume;
								d2_q    <= '0;
								rdot_q  <= '0;
								op_q    <= OP_H0;
								state_q <= S_MLO;
							end
							REQ_CLEAR: begin
								for (int j = 0; j < 3; j++) begin
									thrust_q[j] <= '0;
									torque_q[j] <= '0;
									nf_q[j]     <= '0;
								end
								state_q <= S_DONE;
							end
							REQ_NONE: begin
								for (int j = 0; j < 3; j++)
									nf_q[j] <= '0;
								state_q <= S_DONE;
							end
						endcase
					end
				end

				S_DIV: begin
					div_cnt_q <= div_cnt_q + 6'd1;
					div_num_q <= q_nx;
					div_rem_q <= rem_nx;
					if (div_cnt_q == DIV_LAST) begin
						// The quotient is complete; chain it into the next division or store it.
						div_rem_q <= '0;
						case (div_step_q)
							DV_INV_A: begin
								div_step_q <= DV_INV_B;
							end
							DV_INV_B: begin
								inv_q      <= cap32(q_nx);
								div_num_q  <= two ? C2_NORM : C3_NORM;
								div_step_q <= DV_NORM_A;
							end
							DV_NORM_A: begin
								div_step_q <= DV_NORM_B;
							end
							DV_NORM_B: begin
								if (two) begin
									norm_q  <= cap32(q_nx);
									state_q <= S_DONE;
								end else begin
									div_step_q <= DV_NORM_C;
								end
							end
							default: begin
								norm_q  <= cap32(q_nx);
								state_q <= S_DONE;
							end
						endcase
					end
				end

				S_MLO: begin
					p_lo_q  <= product;
					state_q <= S_MHI;
				end

				S_MHI: begin
					p_hi_q  <= product;
					state_q <= S_MFIN;
				end

				S_MFIN: begin
					case (op.dest)
						D_D2:    d2_q <= d2_q + m64;
						D_X:     x_q  <= m[20:0];
						D_G:     g_q  <= m[31:0];
						D_NF:    nf_q[op.lane] <= clamp32(65'(sv));
						D_THR:   thrust_q[op.lane] <= clamp48(thr_sum);
						D_RDOT:  rdot_q <= rdot_q + 40'(sv);
						D_RP:    rp_q[op.lane] <= 40'(r_w[op.lane]) - 40'(sv);
						D_CSET:  c_q <= 56'(sv);
						D_CSUB:  c_q <= c_q - 56'(sv);
						D_TRQ:   torque_q[op.lane] <= clamp48(trq_sum);
						default: ;
					endcase
					if (op_q == OP_X) begin
						state_q <= S_LOOK;
					end else if (op_q == OP_LAST) begin
						state_q <= S_DONE;
					end else begin
						op_q    <= op_q + 5'd1;
						state_q <= S_MLO;
					end
				end

				S_LOOK: begin
					e_q     <= e_lookup;
					op_q    <= OP_G;
					state_q <= S_MLO;
				end

				S_DONE: begin
					// Hand the result over once the output register is free.
					if (!res_valid_q || !res_stall) begin
						for (int j = 0; j < 3; j++) begin
							res_nf_q[j]  <= nf_q[j];
							res_thr_q[j] <= thrust_q[j];
							res_trq_q[j] <= torque_q[j];
						end
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid    = res_valid_q;
	assign node_force_x = res_nf_q[0];
	assign node_force_y = res_nf_q[1];
	assign node_force_z = res_nf_q[2];
	assign thrust_x     = res_thr_q[0];
	assign thrust_y     = res_thr_q[1];
	assign thrust_z     = res_thr_q[2];
	assign torque_x     = res_trq_q[0];
	assign torque_y     = res_trq_q[1];
	assign torque_z     = res_trq_q[2];

endmodule

`default_nettype wire
